/* hdl/pcpsb_pkg.sv */
// Package: shared types and constants of the polar scan binner.
`timescale 1ns / 1ps
package pcpsb_pkg;

	localparam int CordicSteps = 16;
	localparam int PreShift = 12;
	localparam logic [15:0] NoReturn = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_POINT = 2'd0,
		MODE_READ  = 2'd1,
		MODE_FRAME = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_Z_LOW   = 3'd0,
		REG_Z_HIGH  = 3'd1,
		REG_NEAR    = 3'd2,
		REG_FAR     = 3'd3,
		REG_REFLECT = 3'd4,
		REG_TAG     = 3'd5,
		REG_DECIM   = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ITER,
		ST_FETCH,
		ST_READ,
		ST_UPDATE,
		ST_OUT,
		ST_CLEAR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the input word
		logic point;    // point word taken, advance decimation
		logic check;    // evaluate filters, prepare cordic/sqrt
		logic iter;     // one cordic step and one or two sqrt steps
		logic rd;       // issue memory read
		logic update;   // write bin if nearer
		logic rd_clear; // clear the bin that was read
		logic out_load; // load output register
		logic frame;    // frame start
		logic clear;    // clearing pass write
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic consider_ok; // point passed decimation and filters
		logic iter_done;
		logic clear_done;
	} stat_t;

	function automatic logic [31:0] atan_entry(input logic [3:0] i);
		case (i)
			4'd0:  atan_entry = 32'd536870912;
			4'd1:  atan_entry = 32'd316933406;
			4'd2:  atan_entry = 32'd167458907;
			4'd3:  atan_entry = 32'd85004756;
			4'd4:  atan_entry = 32'd42667331;
			4'd5:  atan_entry = 32'd21354465;
			4'd6:  atan_entry = 32'd10679838;
			4'd7:  atan_entry = 32'd5340245;
			4'd8:  atan_entry = 32'd2670163;
			4'd9:  atan_entry = 32'd1335087;
			4'd10: atan_entry = 32'd667544;
			4'd11: atan_entry = 32'd333772;
			4'd12: atan_entry = 32'd166886;
			4'd13: atan_entry = 32'd83443;
			4'd14: atan_entry = 32'd41722;
			default: atan_entry = 32'd20861;
		endcase
	endfunction

endpackage

/* hdl/pcpsb_if.sv */
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface pcpsb_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [17:0] x_mm;
	logic signed [17:0] y_mm;
	logic signed [17:0] z_mm;
	logic [7:0]        reflect;
	logic [7:0]        point_tag;
	logic [8:0]        read_bin;
	modport source (output valid, mode, x_mm, y_mm, z_mm, reflect, point_tag, read_bin,
		input ready);
	modport sink (input valid, mode, x_mm, y_mm, z_mm, reflect, point_tag, read_bin,
		output ready);
endinterface

interface pcpsb_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  bin_number;
	logic [15:0] range_mm;
	logic [7:0]  intensity;
	logic [15:0] points_used;
	modport source (output valid, bin_number, range_mm, intensity, points_used,
		input ready);
	modport sink (input valid, bin_number, range_mm, intensity, points_used,
		output ready);
endinterface

/* hdl/pcpsb_ctrl.sv */
// Controller: sequences one word at a time through the datapath.
`timescale 1ns / 1ps
module pcpsb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_mode,
	output logic             out_valid,
	input  logic             out_ready,
	input  pcpsb_pkg::stat_t stat,
	output pcpsb_pkg::ctrl_t ctrl
);
	import pcpsb_pkg::*;

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   accept;

	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_POINT: state_next = ST_CHECK;
						MODE_READ:  state_next = ST_READ;
						default:    state_next = ST_IDLE;
					endcase
				end
			end
			ST_CHECK: state_next = stat.consider_ok ? ST_ITER : ST_IDLE;
			ST_ITER:  if (stat.iter_done) state_next = ST_FETCH;
			ST_FETCH: state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_IDLE;
			ST_READ:  state_next = ST_OUT;
			ST_OUT:   state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: ctrl.clear = 1'b1;
			ST_IDLE: begin
				// a pending result holds off every word
				in_ready = !(out_valid_q && !out_ready);
				ctrl.load = accept;
				ctrl.point = accept && (in_mode == MODE_POINT);
				ctrl.frame = accept && (in_mode == MODE_FRAME);
				ctrl.rd = accept && (in_mode == MODE_READ);
			end
			ST_CHECK:  ctrl.check = 1'b1;
			ST_ITER:   ctrl.iter = 1'b1;
			ST_FETCH:  ctrl.rd = 1'b1;
			ST_UPDATE: ctrl.update = 1'b1;
			ST_READ:   ctrl.rd_clear = 1'b1;
			ST_OUT:    ctrl.out_load = 1'b1;
			default:   ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctrl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/pcpsb_dp.sv */
// Datapath: filters, cordic angle, bit-serial square root, bin memory.
`timescale 1ns / 1ps
module pcpsb_dp #(
	parameter int NUM_BINS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pcpsb_pkg::ctrl_t   ctrl,
	output pcpsb_pkg::stat_t   stat,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic signed [17:0] x_mm,
	input  logic signed [17:0] y_mm,
	input  logic signed [17:0] z_mm,
	input  logic [7:0]         reflect,
	input  logic [7:0]         point_tag,
	input  logic [8:0]         read_bin,
	output logic [8:0]         bin_number,
	output logic [15:0]        range_mm,
	output logic [7:0]         intensity,
	output logic [15:0]        points_used
);
	import pcpsb_pkg::*;

	localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CW = 33; // 18-bit input shifted by 12 plus cordic growth

	// configuration
	logic signed [17:0] z_low_q, z_high_q;
	logic [15:0] near_q, far_q;
	logic [7:0]  refl_floor_q, decim_q;
	logic signed [8:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_low_q <= -18'sd550;
			z_high_q <= -18'sd150;
			near_q <= 16'd200;
			far_q <= 16'd4000;
			refl_floor_q <= 8'd0;
			tag_q <= -9'sd1;
			decim_q <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_Z_LOW:   z_low_q <= cfg_data;
				REG_Z_HIGH:  z_high_q <= cfg_data;
				REG_NEAR:    near_q <= cfg_data[15:0];
				REG_FAR:     far_q <= cfg_data[15:0];
				REG_REFLECT: refl_floor_q <= cfg_data[7:0];
				REG_TAG:     tag_q <= cfg_data[8:0];
				REG_DECIM:   decim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured word
	logic signed [17:0] x_q, y_q, z_q;
	logic [7:0] refl_q, tag_in_q;
	logic [8:0] rbin_q;
	logic consider_q;
	logic [7:0] dcount_q;
	logic [15:0] used_q;
	logic [7:0] step;

	assign step = (decim_q == 8'd0) ? 8'd1 : decim_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_mm;
			y_q <= y_mm;
			z_q <= z_mm;
			refl_q <= reflect;
			tag_in_q <= point_tag;
			rbin_q <= read_bin;
		end
	end

	// squared range, computed in check then held
	logic [35:0] x2, y2;
	logic [36:0] r2;
	logic [31:0] near2, far2;
	logic filt_ok;
	assign x2 = 36'(x_q * x_q);
	assign y2 = 36'(y_q * y_q);
	assign r2 = {1'b0, x2} + {1'b0, y2};
	assign near2 = near_q * near_q;
	assign far2 = far_q * far_q;

	always_comb begin
		filt_ok = consider_q;
		if (x_q == 18'sd0 && y_q == 18'sd0 && z_q == 18'sd0) filt_ok = 1'b0;
		if (z_q < z_low_q || z_q > z_high_q) filt_ok = 1'b0;
		if (!tag_q[8] && (tag_q[7:0] != tag_in_q)) filt_ok = 1'b0;
		if (refl_q < refl_floor_q) filt_ok = 1'b0;
		if (r2 < {5'd0, near2} || r2 > {5'd0, far2}) filt_ok = 1'b0;
	end

	// cordic and square root: one cordic step per cycle, with one or two root bit pairs
	logic signed [CW-1:0] cx_q, cy_q, cxs, cys;
	logic [31:0] ph_q;
	logic [4:0] it_q;
	logic [36:0] sq_v_q, sq_r_q, sq_b_q;
	logic iter_done;

	assign cxs = cx_q >>> it_q[3:0];
	assign cys = cy_q >>> it_q[3:0];
	assign iter_done = (it_q == 5'(CordicSteps - 1)) && ctrl.iter;

	// square root needs 19 bit pairs: two per cordic step in the first three
	// steps, one in each of the remaining thirteen steps
	function automatic logic [73:0] sq_step(input logic [36:0] v, input logic [36:0] r,
		input logic [36:0] b);
		logic [36:0] nv, nr;
		begin
			if (v >= r + b) begin
				nv = v - (r + b);
				nr = (r >> 1) + b;
			end else begin
				nv = v;
				nr = r >> 1;
			end
			sq_step = {nv, nr};
		end
	endfunction

	logic [73:0] s1, s2;
	logic [36:0] b_mid;
	assign s1 = sq_step(sq_v_q, sq_r_q, sq_b_q);
	assign b_mid = sq_b_q >> 2;
	assign s2 = sq_step(s1[73:37], s1[36:0], b_mid);

	always_ff @(posedge clk) begin
		if (ctrl.check) begin
			it_q <= '0;
			if (x_q < 0) begin
				cx_q <= -(CW'(x_q) <<< PreShift);
				cy_q <= -(CW'(y_q) <<< PreShift);
				ph_q <= 32'h8000_0000;
			end else begin
				cx_q <= CW'(x_q) <<< PreShift;
				cy_q <= CW'(y_q) <<< PreShift;
				ph_q <= 32'd0;
			end
			sq_v_q <= r2;
			sq_r_q <= '0;
			sq_b_q <= 37'd1 << 36;
		end else if (ctrl.iter) begin
			it_q <= it_q + 5'd1;
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				ph_q <= ph_q + atan_entry(it_q[3:0]);
			end else begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				ph_q <= ph_q - atan_entry(it_q[3:0]);
			end
			// two bit-pairs in the first three steps, one after
			if (it_q < 5'd3) begin
				sq_v_q <= s2[73:37];
				sq_r_q <= s2[36:0];
				sq_b_q <= sq_b_q >> 4;
			end else begin
				sq_v_q <= s1[73:37];
				sq_r_q <= s1[36:0];
				sq_b_q <= b_mid;
			end
		end
	end

	// bin from phase; 44-bit product, bits from 32 upward taken
	logic [31:0] ph_off;
	logic [BW-1:0] pbin;
	logic [43:0] pprod;
	assign ph_off = ph_q + 32'h8000_0000;
	assign pprod = {12'd0, ph_off} * 44'(NUM_BINS);
	assign pbin = pprod[32 +: BW];

	// bin memory, with clearing pass after reset
	logic [15:0] mem_r [NUM_BINS];
	logic [7:0]  mem_i [NUM_BINS];
	logic [15:0] rd_r_q;
	logic [7:0]  rd_i_q;
	logic [BW-1:0] addr_q, clr_q, rd_addr;
	logic [BW:0] rd_full;
	logic bin_ok;
	logic clear_done;

	assign rd_full = (BW + 1)'(rbin_q);
	assign bin_ok = ({1'b0, rbin_q} < 10'(NUM_BINS)) || (BW > 9);
	// read words address the table straight from the input, points from the phase
	assign rd_addr = ctrl.load ? BW'(read_bin) : pbin;
	assign clear_done = ctrl.clear && (clr_q == BW'(NUM_BINS - 1));

	assign stat = {filt_ok, iter_done, clear_done};

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_r_q <= mem_r[rd_addr];
			rd_i_q <= mem_i[rd_addr];
			addr_q <= rd_addr;
		end
		if (ctrl.clear) begin
			mem_r[clr_q] <= NoReturn;
			mem_i[clr_q] <= 8'd0;
		end else if (ctrl.update) begin
			if (sq_r_q[15:0] < rd_r_q && sq_r_q[36:16] == '0) begin
				mem_r[addr_q] <= sq_r_q[15:0];
				mem_i[addr_q] <= refl_q;
			end
		end else if (ctrl.rd_clear && bin_ok && rd_full[BW] == 1'b0) begin
			mem_r[addr_q] <= NoReturn;
			mem_i[addr_q] <= 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			dcount_q <= '0;
			used_q <= '0;
			consider_q <= 1'b0;
		end else begin
			if (ctrl.clear) clr_q <= clr_q + BW'(1);
			if (ctrl.frame) begin
				dcount_q <= '0;
				used_q <= '0;
			end
			if (ctrl.point) begin
				consider_q <= (dcount_q == 8'd0);
				dcount_q <= ({1'b0, dcount_q} + 9'd1 >= {1'b0, step}) ?
					8'd0 : dcount_q + 8'd1;
			end
			if (ctrl.check) begin
				consider_q <= 1'b0;
				if (filt_ok && used_q != 16'hFFFF) used_q <= used_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			bin_number <= rbin_q;
			range_mm <= bin_ok ? rd_r_q : NoReturn;
			intensity <= bin_ok ? rd_i_q : 8'd0;
			points_used <= used_q;
		end
	end

endmodule

/* hdl/point_cloud_to_polar_scan_binner.sv */
// Polar scan binner: one word at a time. A point that passes decimation and
// the filters goes through accept, filter check, 16 CORDIC steps that also run
// the bit-serial square root, bin lookup and bin update before the next word
// is taken; a rejected point ends at the filter check. A read is looked up on
// accept, then its bin is cleared and the output register loaded; frame start
// and unused words end on accept. While a result waits on the output no word is
// taken. After reset a clearing pass over all NUM_BINS bins sets every bin to
// no return before the first word is taken.
`timescale 1ns / 1ps
module point_cloud_to_polar_scan_binner #(
	parameter int NUM_BINS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	pcpsb_in_if.sink    in_ch,
	pcpsb_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import pcpsb_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	pcpsb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .ctrl(ctrl)
	);

	pcpsb_dp #(.NUM_BINS(NUM_BINS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.x_mm(in_ch.x_mm), .y_mm(in_ch.y_mm), .z_mm(in_ch.z_mm),
		.reflect(in_ch.reflect), .point_tag(in_ch.point_tag), .read_bin(in_ch.read_bin),
		.bin_number(out_ch.bin_number), .range_mm(out_ch.range_mm),
		.intensity(out_ch.intensity), .points_used(out_ch.points_used)
	);

endmodule

/* hdl/pcpsb_checker.sv */
// Checker: port-level properties of the binner, bound to the top level.
`timescale 1ns / 1ps
module pcpsb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [15:0] range_mm,
	input logic [7:0]  intensity
);
	import pcpsb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_noread: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode == MODE_POINT |=> !in_ready)
		else $error("ready during point work");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_mm == NoReturn |-> intensity == 8'd0)
		else $error("intensity on empty bin");
endmodule

bind point_cloud_to_polar_scan_binner pcpsb_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.range_mm(out_ch.range_mm), .intensity(out_ch.intensity)
);

/* tb/sv/point_cloud_to_polar_scan_binner_chk.sv */
// Checker: predicts the binner's read words and compares them with the output channel.
`timescale 1ns / 1ps
module point_cloud_to_polar_scan_binner_chk #(
	parameter int NUM_BINS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	pcpsb_in_if         in_ch,
	pcpsb_out_if        out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	output int          fails,
	output int          pending
);
	import pcpsb_pkg::*;

	typedef struct packed {
		logic [8:0]  bin_number;
		logic [15:0] range_mm;
		logic [7:0]  intensity;
		logic [15:0] points_used;
	} scan_word_t;

	scan_word_t scan_q[$];

	logic signed [17:0] z_lo, z_hi;
	logic [15:0] near_mm, far_mm;
	logic [7:0] refl_min, step_n;
	logic signed [8:0] tag_req;
	logic [15:0] nearest[NUM_BINS];
	logic [7:0] nearest_refl[NUM_BINS];
	logic [7:0] skip_cnt;
	logic [15:0] used_cnt;

	assign pending = scan_q.size();

	// vectoring cordic, phase in 2^32 per turn
	function automatic logic [31:0] heading(input longint px, input longint py);
		longint ax, ay, sx, sy;
		logic [31:0] ang;
		ax = px * 4096;
		ay = py * 4096;
		ang = '0;
		if (ax < 0) begin
			ax = -ax;
			ay = -ay;
			ang = 32'h8000_0000;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			sx = ax >>> i;
			sy = ay >>> i;
			if (ay >= 0) begin
				ax = ax + sy;
				ay = ay - sx;
				ang = ang + atan_entry(4'(i));
			end else begin
				ax = ax - sy;
				ay = ay + sx;
				ang = ang - atan_entry(4'(i));
			end
		end
		return ang;
	endfunction

	function automatic longint floor_root(input longint v);
		longint res, t;
		res = 0;
		for (int b = 20; b >= 0; b--) begin
			t = res + (longint'(1) << b);
			if (t * t <= v)
				res = t;
		end
		return res;
	endfunction

	task automatic take_point();
		longint px, py, pz, r2, rr;
		logic [31:0] ph;
		int b;
		logic [7:0] stepv;
		logic keep;
		px = longint'(in_ch.x_mm);
		py = longint'(in_ch.y_mm);
		pz = longint'(in_ch.z_mm);
		stepv = (step_n == 0) ? 8'd1 : step_n;
		keep = (skip_cnt == 0);
		skip_cnt = skip_cnt + 1;
		if (skip_cnt >= stepv)
			skip_cnt = 0;
		if (!keep) return;
		if (px == 0 && py == 0 && pz == 0) return;
		if (pz < longint'(z_lo) || pz > longint'(z_hi)) return;
		if (tag_req >= 0 && int'(in_ch.point_tag) != int'(tag_req)) return;
		if (in_ch.reflect < refl_min) return;
		r2 = px * px + py * py;
		if (r2 < longint'(near_mm) * near_mm || r2 > longint'(far_mm) * far_mm) return;
		ph = heading(px, py) + 32'h8000_0000;
		b = int'((longint'(ph) * NUM_BINS) >> 32);
		if (b >= NUM_BINS)
			b = NUM_BINS - 1;
		rr = floor_root(r2);
		if (rr < longint'(nearest[b])) begin
			nearest[b] = 16'(rr);
			nearest_refl[b] = in_ch.reflect;
		end
		if (used_cnt != 16'hFFFF)
			used_cnt = used_cnt + 1;
	endtask

	task automatic read_bin_word();
		scan_word_t w;
		int b;
		b = int'(in_ch.read_bin);
		w.bin_number = in_ch.read_bin;
		w.points_used = used_cnt;
		if (b < NUM_BINS) begin
			w.range_mm = nearest[b];
			w.intensity = nearest_refl[b];
			nearest[b] = NoReturn;
			nearest_refl[b] = '0;
		end else begin
			w.range_mm = NoReturn;
			w.intensity = '0;
		end
		scan_q.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_word_t exp_w, got_w;
		if (!arst_n) begin
			z_lo <= -18'sd550;
			z_hi <= -18'sd150;
			near_mm <= 16'd200;
			far_mm <= 16'd4000;
			refl_min <= '0;
			tag_req <= -9'sd1;
			step_n <= 8'd4;
			for (int i = 0; i < NUM_BINS; i++) begin
				nearest[i] = NoReturn;
				nearest_refl[i] = '0;
			end
			skip_cnt = '0;
			used_cnt = '0;
			fails <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_Z_LOW:   z_lo <= cfg_data;
					REG_Z_HIGH:  z_hi <= cfg_data;
					REG_NEAR:    near_mm <= cfg_data[15:0];
					REG_FAR:     far_mm <= cfg_data[15:0];
					REG_REFLECT: refl_min <= cfg_data[7:0];
					REG_TAG:     tag_req <= cfg_data[8:0];
					REG_DECIM:   step_n <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (mode_t'(in_ch.mode))
					MODE_POINT: take_point();
					MODE_READ:  read_bin_word();
					MODE_FRAME: begin
						skip_cnt = '0;
						used_cnt = '0;
					end
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got_w = {out_ch.bin_number, out_ch.range_mm, out_ch.intensity,
					out_ch.points_used};
				if (scan_q.size() == 0) begin
					fails <= fails + 1;
					if (fails < 10)
						$display("unexpected word: bin %0d range %0d int %0d used %0d",
							got_w.bin_number, got_w.range_mm, got_w.intensity,
							got_w.points_used);
				end else begin
					exp_w = scan_q.pop_front();
					if (got_w !== exp_w) begin
						fails <= fails + 1;
						if (fails < 10)
							$display({"word mismatch: exp bin %0d range %0d int %0d ",
								"used %0d, got bin %0d range %0d int %0d used %0d"},
								exp_w.bin_number, exp_w.range_mm, exp_w.intensity,
								exp_w.points_used, got_w.bin_number, got_w.range_mm,
								got_w.intensity, got_w.points_used);
					end
				end
			end
		end
	end

endmodule

/* tb/sv/point_cloud_to_polar_scan_binner_tb.sv */
// Testbench top: clock, reset, stimulus phases and verdict for the polar scan binner.
`timescale 1ns / 1ps
module point_cloud_to_polar_scan_binner_tb;
	import pcpsb_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [17:0] cfg_data;
	int fails, pending;
	int gap_pct, stall_pct;

	// current register values, used to aim points at the windows
	int z_lo, z_hi, near_mm, far_mm, refl_min, tag_req, step_n;

	pcpsb_in_if in_ch ();
	pcpsb_out_if out_ch ();

	point_cloud_to_polar_scan_binner uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	point_cloud_to_polar_scan_binner_chk chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#5ms;
		$display("point_cloud_to_polar_scan_binner: mismatch");
		$finish;
	end

	task automatic send(input mode_t m, input int x, input int y, input int z,
		input int refl, input int tag, input int rbin);
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.x_mm <= 18'(x);
		in_ch.y_mm <= 18'(y);
		in_ch.z_mm <= 18'(z);
		in_ch.reflect <= 8'(refl);
		in_ch.point_tag <= 8'(tag);
		in_ch.read_bin <= 9'(rbin);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// hold the input until all read words are back and the last point is done
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(input int zl, input int zh, input int nr, input int fr,
		input int rf, input int tg, input int st);
		int vals[7];
		vals = '{zl, zh, nr, fr, rf, tg, st};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= 18'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		z_lo = zl; z_hi = zh; near_mm = nr; far_mm = fr;
		refl_min = rf; tag_req = tg; step_n = st;
	endtask

	task automatic point_aimed();
		int r, d, x, y, z, tg, rf;
		int dxs[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
		int dys[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
		r = (far_mm >= near_mm) ? $urandom_range(near_mm, far_mm) : $urandom_range(65534);
		d = $urandom_range(7);
		if (dxs[d] != 0 && dys[d] != 0) begin
			x = dxs[d] * r * 7 / 10;
			y = dys[d] * r * 7 / 10;
		end else begin
			x = dxs[d] * r;
			y = dys[d] * r;
		end
		if ($urandom_range(3) == 0) begin
			x = x + $urandom_range(40) - 20;
			y = y + $urandom_range(40) - 20;
		end
		z = (z_hi >= z_lo) ? z_lo + int'($urandom_range(z_hi - z_lo)) : 0;
		tg = (tag_req >= 0 && $urandom_range(7) != 0) ? tag_req : $urandom_range(255);
		rf = $urandom_range(refl_min, 255);
		send(MODE_POINT, x, y, z, rf, tg, $urandom_range(511));
	endtask

	task automatic random_word();
		int sel;
		int hot[14] = '{0, 1, 63, 64, 127, 128, 192, 255, 256, 320, 383, 384, 448, 511};
		sel = $urandom_range(99);
		if (sel < 60)
			point_aimed();
		else if (sel < 75)
			send(MODE_POINT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 94)
			send(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
				($urandom_range(3) != 0) ? hot[$urandom_range(13)] : $urandom_range(511));
		else if (sel < 98)
			send(MODE_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int gaps[4] = '{0, 62, 0, 6};
		int stalls[4] = '{0, 0, 62, 6};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_POINT;
		in_ch.x_mm = '0;
		in_ch.y_mm = '0;
		in_ch.z_mm = '0;
		in_ch.reflect = '0;
		in_ch.point_tag = '0;
		in_ch.read_bin = '0;
		out_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		z_lo = -550; z_hi = -150; near_mm = 200; far_mm = 4000;
		refl_min = 0; tag_req = -1; step_n = 4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: default decimation by four
		send(MODE_POINT, 1000, 0, -300, 50, 1, 0);
		send(MODE_POINT, 0, 1000, -300, 50, 1, 0);
		send(MODE_READ, 0, 0, 0, 0, 0, 256);
		drain();
		configure(-131072, 131071, 0, 65534, 0, -1, 1);
		send(MODE_FRAME, 0, 0, 0, 0, 0, 0);
		send(MODE_POINT, 0, 0, 0, 200, 3, 0);                // all zero, dropped
		send(MODE_POINT, 0, 0, 77, 200, 3, 0);               // origin, z set
		send(MODE_POINT, -1000, 0, 0, 11, 0, 0);             // angle at +pi
		send(MODE_POINT, -131072, -131072, 131071, 255, 255, 0);
		send(MODE_POINT, 131071, 131071, -131072, 0, 0, 0);
		send(MODE_POINT, 1000, 0, 0, 255, 255, 0);
		send(MODE_POINT, 1000, 0, 0, 7, 255, 0);             // tie keeps the first
		send(MODE_NONE, 5, 5, 5, 5, 5, 5);
		send(MODE_READ, 0, 0, 0, 0, 0, 256);
		send(MODE_READ, 0, 0, 0, 0, 0, 256);
		send(MODE_READ, 0, 0, 0, 0, 0, 0);
		send(MODE_READ, 0, 0, 0, 0, 0, 511);
		drain();
		configure(-100, 100, 500, 2000, 10, 5, 0);            // zero step acts as one
		send(MODE_POINT, 0, 1500, 0, 10, 5, 0);
		send(MODE_POINT, 0, 1400, 0, 9, 5, 0);
		send(MODE_POINT, 0, 1300, 0, 30, 6, 0);
		send(MODE_POINT, 0, 1200, 101, 30, 5, 0);
		send(MODE_POINT, 0, 400, 0, 30, 5, 0);
		send(MODE_READ, 0, 0, 0, 0, 0, 384);
		send(MODE_FRAME, 0, 0, 0, 0, 0, 0);
		send(MODE_READ, 0, 0, 0, 0, 0, 384);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			gap_pct = gaps[ph % 4];
			stall_pct = stalls[ph % 4];
			case (ph)
				3: configure(-131072, 131071, 65534, 65534, 255, 255, 255);
				5: configure(131071, -131072, 0, 0, 0, -1, 2);
				6: configure(-131072, 131071, 0, 65534, 0, -1, 1);
				default: configure(-int'($urandom_range(2000)), $urandom_range(2000),
					$urandom_range(500), $urandom_range(1000, 65534), $urandom_range(50),
					($urandom_range(1) != 0) ? -1 : int'($urandom_range(255)),
					$urandom_range(1, 4));
			endcase
			repeat (240) random_word();
			drain();
		end

		if (fails == 0)
			$display("point_cloud_to_polar_scan_binner: match");
		else
			$display("point_cloud_to_polar_scan_binner: mismatch");
		$finish;
	end

endmodule
